// ----- sv/hall_key_percent_hysteresis_core_assert.svh -----
// Assertion macros used by the RTL of the Hall key travel core.
`ifndef HALL_KEY_PERCENT_HYSTERESIS_CORE_ASSERT_SVH
`define HALL_KEY_PERCENT_HYSTERESIS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HKPH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hkph assertion failed");

// Next-cycle implication, checked outside reset.
`define HKPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hkph assertion failed");

`endif

// ----- sv/hkph_pkg.sv -----
// Types, codes and constants of the Hall key travel core.
`default_nettype none

package hkph_pkg;

	localparam int SWITCH_SLOTS = 16;
	localparam int SLOT_W       = $clog2(SWITCH_SLOTS);

	localparam int OP_W    = 3;
	localparam int IDX_W   = 4;
	localparam int RAW_W   = 12;
	localparam int SENS_W  = 8;
	localparam int SSTO_W  = 7;
	localparam int PCT_W   = 7;
	localparam int STG_W   = 3;
	localparam int ACT_W   = 5;

	// divider: 19-bit dividend, 12-bit divisor, 12 quotient bits
	localparam int NUM_W     = RAW_W + PCT_W;
	localparam int DEN_W     = RAW_W;
	localparam int QUO_W     = 12;
	localparam int DSH_W     = DEN_W + QUO_W - 1;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [RAW_W-1:0]  RAW_FULL     = 12'd4095;
	localparam logic [PCT_W-1:0]  PRESS_PCT    = 7'd100;
	localparam logic [PCT_W-1:0]  RELEASE_PCT  = 7'd98;
	localparam logic [PCT_W-1:0]  PCT_SCALE    = 7'd100;
	localparam logic [SSTO_W-1:0] DEFAULT_SENS = 7'd50;
	localparam logic [SENS_W-1:0] MAX_SENS     = 8'd100;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE    = 3'd0,
		OP_CAL_START = 3'd1,
		OP_CAP_LOW   = 3'd2,
		OP_CAP_HIGH  = 3'd3,
		OP_CAL_DONE  = 3'd4,
		OP_SET_SENS  = 3'd5
	} op_t;

	typedef enum logic [STG_W-1:0] {
		STG_NONE  = 3'd0,
		STG_READY = 3'd1,
		STG_LOW   = 3'd2,
		STG_HIGH  = 3'd3,
		STG_DONE  = 3'd4
	} cal_stage_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL,
		S_DIV,
		S_FIN
	} fsm_t;

	// per-switch record, one RAM word
	typedef struct packed {
		logic [RAW_W-1:0]  lo;
		logic [RAW_W-1:0]  hi;
		logic [SSTO_W-1:0] sens;
		logic [RAW_W-1:0]  thr;
		logic              cal;
		logic              pressed;
		cal_stage_t        stage;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	localparam rec_t RESET_REC = '{
		lo:      12'd100,
		hi:      12'd3000,
		sens:    7'd20,
		thr:     12'd680,
		cal:     1'b1,
		pressed: 1'b0,
		stage:   STG_NONE
	};

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] switch_echo;
		logic             accepted;
		logic             state_changed;
		logic             key_down;
		logic [PCT_W-1:0] travel_percent;
		logic [RAW_W-1:0] trigger_level;
		logic [STG_W-1:0] cal_stage;
	} rsp_t;

endpackage

`default_nettype wire

// ----- sv/hkph_req_if.sv -----
// Input item channel of the Hall key travel core.
`default_nettype none

interface hkph_req_if
	import hkph_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [IDX_W-1:0]  switch_index;
	logic [RAW_W-1:0]  adc_sample;
	logic [SENS_W-1:0] new_sensitivity;

	modport source (
		output valid, op, switch_index, adc_sample, new_sensitivity,
		input  ready
	);
	modport sink (
		input  valid, op, switch_index, adc_sample, new_sensitivity,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/hkph_rsp_if.sv -----
// Result item channel of the Hall key travel core.
`default_nettype none

interface hkph_rsp_if
	import hkph_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] switch_echo;
	logic             accepted;
	logic             state_changed;
	logic             key_down;
	logic [PCT_W-1:0] travel_percent;
	logic [RAW_W-1:0] trigger_level;
	logic [STG_W-1:0] cal_stage;

	modport source (
		output valid, switch_echo, accepted, state_changed, key_down,
			travel_percent, trigger_level, cal_stage,
		input  ready
	);
	modport sink (
		input  valid, switch_echo, accepted, state_changed, key_down,
			travel_percent, trigger_level, cal_stage,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/hall_key_percent_hysteresis_core.sv -----
// Hall key travel core: per-switch calibration, travel percent and press hysteresis.
// Usage:
//  - req carries one item (op, switch_index, adc_sample, new_sensitivity);
//    it is taken at a clock edge with req.valid and req.ready high.
//  - rsp returns exactly one result item per request item, in order, taken
//    at an edge with rsp.valid and rsp.ready high.
//  - cfg_we/cfg_wdata write active_switches; write only while idle.
//  - One item at a time. The per-switch record is read from a RAM with
//    registered read data, evaluated, optionally scaled by a 12-step radix-2
//    divider and written back. The divider is used for samples between
//    the ends, calibration complete and sensitivity set on a calibrated switch.
//  - The result is written to the output register as the item leaves S_FIN.
//  - Reset clears active_switches and the RAM valid bits: every switch reads
//    its reset record until first written back, so no clearing pass is run.
//  - A stalled receiver holds the result; the next item is still accepted
//    and processed, and waits in its final step until the output is free.
`default_nettype none
`include "hall_key_percent_hysteresis_core_assert.svh"

module hall_key_percent_hysteresis_core
	import hkph_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	hkph_req_if.sink              req,
	hkph_rsp_if.source            rsp,
	input  wire logic             cfg_we,
	input  wire logic [ACT_W-1:0] cfg_wdata
);
	fsm_t state_q, state_d;

	logic [ACT_W-1:0]        active_q;
	logic [SWITCH_SLOTS-1:0] valid_q;

	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [RAW_W-1:0]  raw_q;
	logic [SENS_W-1:0] sens_q;
	logic              rej_q;

	rec_t              rec_q;
	logic              use_div_q;
	logic [PCT_W-1:0]  pct_fix_q;
	logic [RAW_W-1:0]  mul_a_q;
	logic [PCT_W-1:0]  mul_b_q;
	logic [DEN_W-1:0]  div_d_q;

	logic              out_valid_q;
	rsp_t              out_q;

	logic              accept;
	logic              fin_go;
	logic              rej_in;

	logic [REC_W-1:0]  rd_raw;
	rec_t              eff;
	logic              use_div_c;
	logic [PCT_W-1:0]  pct_fix_c;
	logic [RAW_W-1:0]  mul_a_c;
	logic [PCT_W-1:0]  mul_b_c;
	logic [DEN_W-1:0]  div_d_c;
	logic [RAW_W-1:0]  lo_c, hi_c, mn_c, mx_c, span_c;

	rec_t              nrec;
	rsp_t              res_c;
	logic [PCT_W-1:0]  pct_c;
	logic [RAW_W-1:0]  recomp_c;
	logic              now_c;

	div_cmd_t          div_cmd;
	logic              div_done;
	logic [QUO_W-1:0]  div_quo;

	assign accept = req.valid && req.ready;
	assign rej_in = ({1'b0, req.switch_index} >= active_q)
		|| (32'(req.switch_index) >= SWITCH_SLOTS);

	// ---------------- FSM ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		fin_go    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = use_div_c ? S_MUL : S_FIN;
			end
			S_MUL: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					fin_go  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ---------------- config and valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			valid_q  <= '0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (fin_go && !rej_q) begin
				valid_q[idx_q[SLOT_W-1:0]] <= 1'b1;
			end
		end
	end

	// ---------------- record RAM ----------------
	hkph_ram #(
		.WIDTH (REC_W),
		.DEPTH (SWITCH_SLOTS)
	) u_rec_ram (
		.clk   (clk),
		.we    (fin_go && !rej_q),
		.waddr (idx_q[SLOT_W-1:0]),
		.wdata (nrec),
		.raddr (req.switch_index[SLOT_W-1:0]),
		.rdata (rd_raw)
	);

	// ---------------- evaluate (read data arrives in S_EVAL) ----------------
	always_comb begin
		eff       = valid_q[idx_q[SLOT_W-1:0]] ? rec_t'(rd_raw) : RESET_REC;
		use_div_c = 1'b0;
		pct_fix_c = '0;
		mul_a_c   = '0;
		mul_b_c   = PCT_SCALE;
		div_d_c   = DEN_W'(PCT_SCALE);
		lo_c      = eff.cal ? eff.lo : '0;
		hi_c      = eff.cal ? eff.hi : RAW_FULL;
		mn_c      = (lo_c > hi_c) ? hi_c : lo_c;
		mx_c      = (lo_c > hi_c) ? lo_c : hi_c;
		span_c    = (eff.hi > eff.lo) ? (eff.hi - eff.lo) : (eff.lo - eff.hi);
		if (!rej_q) begin
			unique case (op_q)
				OP_SAMPLE: begin
					if (raw_q <= mn_c) begin
						pct_fix_c = '0;
					end else if (raw_q >= mx_c) begin
						pct_fix_c = PRESS_PCT;
					end else begin
						use_div_c = 1'b1;
						mul_a_c   = raw_q - mn_c;
						mul_b_c   = PCT_SCALE;
						div_d_c   = mx_c - mn_c;
					end
				end
				OP_CAL_DONE: begin
					if (eff.stage == STG_HIGH) begin
						use_div_c = 1'b1;
						mul_a_c   = span_c;
						mul_b_c   = (eff.sens == '0) ? DEFAULT_SENS : eff.sens;
					end
				end
				OP_SET_SENS: begin
					if (sens_q <= MAX_SENS && eff.cal) begin
						use_div_c = 1'b1;
						mul_a_c   = span_c;
						mul_b_c   = sens_q[SSTO_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			idx_q  <= req.switch_index;
			raw_q  <= req.adc_sample;
			sens_q <= req.new_sensitivity;
			rej_q  <= rej_in;
		end
		if (state_q == S_EVAL) begin
			rec_q     <= eff;
			use_div_q <= use_div_c;
			pct_fix_q <= pct_fix_c;
			mul_a_q   <= mul_a_c;
			mul_b_q   <= mul_b_c;
			div_d_q   <= div_d_c;
		end
	end

	// product goes straight into the divider's remainder register
	assign div_cmd.start = (state_q == S_MUL);
	assign div_cmd.num   = NUM_W'(mul_a_q * mul_b_q);
	assign div_cmd.den   = div_d_q;

	hkph_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ---------------- modify ----------------
	always_comb begin
		nrec     = rec_q;
		pct_c    = use_div_q ? div_quo[PCT_W-1:0] : pct_fix_q;
		recomp_c = (rec_q.hi > rec_q.lo) ? (rec_q.lo + div_quo) : (rec_q.lo - div_quo);
		now_c    = rec_q.pressed ? (pct_c >= RELEASE_PCT) : (pct_c >= PRESS_PCT);
		res_c    = '0;
		res_c.switch_echo = idx_q;
		unique case (op_q)
			OP_SAMPLE: begin
				nrec.pressed        = now_c;
				res_c.accepted      = 1'b1;
				res_c.state_changed = now_c != rec_q.pressed;
				res_c.travel_percent = pct_c;
			end
			OP_CAL_START: begin
				nrec.stage     = STG_READY;
				nrec.cal       = 1'b0;
				res_c.accepted = 1'b1;
			end
			OP_CAP_LOW: begin
				if (rec_q.stage == STG_READY) begin
					nrec.lo        = raw_q;
					nrec.stage     = STG_LOW;
					res_c.accepted = 1'b1;
				end
			end
			OP_CAP_HIGH: begin
				if (rec_q.stage == STG_LOW) begin
					nrec.hi        = raw_q;
					nrec.stage     = STG_HIGH;
					res_c.accepted = 1'b1;
				end
			end
			OP_CAL_DONE: begin
				if (rec_q.stage == STG_HIGH) begin
					nrec.cal       = 1'b1;
					nrec.stage     = STG_DONE;
					nrec.sens      = (rec_q.sens == '0) ? DEFAULT_SENS : rec_q.sens;
					nrec.thr       = recomp_c;
					res_c.accepted = 1'b1;
				end
			end
			OP_SET_SENS: begin
				if (sens_q <= MAX_SENS) begin
					nrec.sens = sens_q[SSTO_W-1:0];
					if (rec_q.cal) begin
						nrec.thr = recomp_c;
					end
					res_c.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_c.key_down      = nrec.pressed;
		res_c.trigger_level = nrec.thr;
		res_c.cal_stage     = nrec.stage;
		if (rej_q) begin
			res_c             = '0;
			res_c.switch_echo = idx_q;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q <= res_c;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.switch_echo    = out_q.switch_echo;
	assign rsp.accepted       = out_q.accepted;
	assign rsp.state_changed  = out_q.state_changed;
	assign rsp.key_down       = out_q.key_down;
	assign rsp.travel_percent = out_q.travel_percent;
	assign rsp.trigger_level  = out_q.trigger_level;
	assign rsp.cal_stage      = out_q.cal_stage;

	// ---------------- assertions ----------------
	`HKPH_ASSERT_NEXT(a_accept_eval, clk, arst_n, accept, state_q == S_EVAL)
	`HKPH_ASSERT_NOW(a_done_in_div, clk, arst_n, div_done, state_q == S_DIV)
	`HKPH_ASSERT_NOW(a_pct_range, clk, arst_n, out_valid_q,
		out_q.travel_percent <= PRESS_PCT)
	`HKPH_ASSERT_NOW(a_reject_quiet, clk, arst_n, out_valid_q && !out_q.accepted,
		!out_q.state_changed && out_q.travel_percent == '0)
endmodule

`default_nettype wire

// ----- sv/hkph_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hkph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

// ----- sv/hkph_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module hkph_div
	import hkph_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_cmd_t         cmd,
	output logic                  done,
	output logic [QUO_W-1:0]      quo
);
	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic             ge;

	// dividend is known to be below divisor << QUO_W
	assign ge = DSH_W'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= cmd.num;
			dsh_q <= {cmd.den, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

`default_nettype wire
